// ===== sv/dssf_pkg.sv =====
// Package: shared types, constants and lookup functions of the seven-segment frame generator.
package dssf_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int VALUE_W     = 16;
    localparam int DIGIT_W     = 4;
    localparam int POS_W       = 2;
    localparam int CNT_W       = $clog2(DIGIT_COUNT + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Reciprocal of ten in 0.19 fixed point; exact for every 16-bit value.
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 16'hCCCD;
    localparam int                 RECIP_SHIFT = 19;

    // One queued frame: position, decimal digit and end-of-run mark.
    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_frame;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_status;

    // Active-low select byte: all ones with bit 4+pos cleared.
    function automatic logic [7:0] select_for(input logic [POS_W-1:0] pos);
        logic [7:0] onehot;
        onehot = 8'h10 << pos;
        return ~onehot;
    endfunction

    // Segments a..g in bits 0..6 for decimal digits.
    function automatic logic [6:0] seg_for(input logic [DIGIT_W-1:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

// ===== sv/decimal_seven_segment_frames.sv =====
// Top level: decimal value to multiplexed seven-segment display frames.
//
// Input channel (i_valid / o_ready / i_value): one 16-bit unsigned word per value.
// Output channel (o_valid / i_ready / o_select_byte, o_segment_byte, o_last_frame):
// five words per value, one per digit position 3 down to 0 and then a blanking
// frame (select 0xEF, segments zero, o_last_frame high). The units digit lands on
// position 3, the thousands digit on position 0; higher digits are dropped.
// The front end emits one frame per cycle while the queue has room, dividing by ten
// through a reciprocal multiply; it works on one value at a time, but takes the next
// value as it pushes the last one's blanking frame. The first frame passes through
// the value register, a queue entry and the output register before it appears.
// A four-entry frame queue sits between front and back: when the receiver stalls
// the back end holds its output register, the queue fills, and only then does the
// front end stop and drop o_ready. Nothing is lost or repeated under any stall.
// Synchronous active-low reset empties the queue, clears the output valid and
// idles the front end; the value, queue storage and output bytes are not reset.
module decimal_seven_segment_frames (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_select_byte,
    output logic [6:0]  o_segment_byte,
    output logic        o_last_frame
);

    dssf_pkg::t_q_status q_status;
    dssf_pkg::t_frame    push_frame;
    dssf_pkg::t_frame    head_frame;
    logic                push;
    logic                pop;

    // Front: take values, emit digit frames and the blanking frame in order.
    dssf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .i_q_status (q_status),
        .o_push     (push),
        .o_frame    (push_frame)
    );

    // Queue: decouple digit extraction from the receiver's stalls.
    dssf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_frame  (push_frame),
        .i_pop    (pop),
        .o_frame  (head_frame),
        .o_status (q_status)
    );

    // Back: look up the bytes and hold them in the output register.
    dssf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_status     (q_status),
        .i_frame        (head_frame),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_select_byte  (o_select_byte),
        .o_segment_byte (o_segment_byte),
        .o_last_frame   (o_last_frame)
    );

    // A blanking frame always selects position 0 with every segment dark.
    a_blank_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_frame |-> o_segment_byte == 7'h00 && o_select_byte == 8'hEF)
        else $error("blanking frame carries wrong bytes");

    // A value keeps the front end busy, so two values are never taken back to back.
    a_no_double_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("front end took a second value while busy");

    // Digit frames follow a blanking frame, never another blanking frame.
    a_no_double_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_frame && i_ready |=> !(o_valid && o_last_frame))
        else $error("two blanking frames in a row");

    // Never push into a full queue.
    a_queue_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("frame pushed into full queue");

endmodule

// ===== sv/dssf_front.sv =====
// Front end: accepts a value and peels off one decimal digit per frame into the queue.
module dssf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dssf_pkg::VALUE_W-1:0]  i_value,
    input  dssf_pkg::t_q_status           i_q_status,
    output logic                          o_push,
    output dssf_pkg::t_frame              o_frame
);

    logic                          r_busy;
    logic                          n_busy;
    logic [dssf_pkg::CNT_W-1:0]    r_cnt;
    logic [dssf_pkg::CNT_W-1:0]    n_cnt;
    logic [dssf_pkg::VALUE_W-1:0]  r_val;
    logic [dssf_pkg::VALUE_W-1:0]  n_val;

    logic [2*dssf_pkg::VALUE_W-1:0] prod;
    logic [dssf_pkg::VALUE_W-1:0]   quot;
    logic [dssf_pkg::VALUE_W-1:0]   rem;
    logic                           at_blank;
    logic                           accept;

    // Divide by ten through the reciprocal, then recover the remainder.
    always_comb begin
        prod = r_val * dssf_pkg::RECIP_TEN;
        quot = dssf_pkg::VALUE_W'(prod >> dssf_pkg::RECIP_SHIFT);
        rem  = r_val - ((quot << 3) + (quot << 1));
    end

    assign at_blank = (r_cnt == dssf_pkg::CNT_W'(dssf_pkg::DIGIT_COUNT));
    assign o_push   = r_busy && !i_q_status.full;
    assign o_ready  = !r_busy || (o_push && at_blank);
    assign accept   = i_valid && o_ready;

    always_comb begin
        o_frame.last  = at_blank;
        o_frame.digit = rem[dssf_pkg::DIGIT_W-1:0];
        o_frame.pos   = at_blank ? '0
                      : dssf_pkg::POS_W'(dssf_pkg::DIGIT_COUNT - 1 - int'(r_cnt));
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_val  = r_val;
        if (o_push) begin
            n_cnt = r_cnt + 1'b1;
            n_val = quot;
            if (at_blank) begin
                n_busy = 1'b0;
            end
        end
        if (accept) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_val  = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_val <= n_val;
    end

endmodule

// ===== sv/dssf_queue.sv =====
// Short frame queue between the front and back ends.
module dssf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  dssf_pkg::t_frame     i_frame,
    input  logic                 i_pop,
    output dssf_pkg::t_frame     o_frame,
    output dssf_pkg::t_q_status  o_status
);

    dssf_pkg::t_frame               r_mem [dssf_pkg::QUEUE_DEPTH];
    logic [dssf_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [dssf_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [dssf_pkg::QCNT_W-1:0]    r_count;
    logic [dssf_pkg::QCNT_W-1:0]    n_count;

    assign o_status.full     = (r_count == dssf_pkg::QCNT_W'(dssf_pkg::QUEUE_DEPTH));
    assign o_status.nonempty = (r_count != '0);
    assign o_frame           = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

// ===== sv/dssf_back.sv =====
// Back end: turns queued frames into select and segment bytes in the output register.
module dssf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dssf_pkg::t_q_status  i_q_status,
    input  dssf_pkg::t_frame     i_frame,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_select_byte,
    output logic [6:0]           o_segment_byte,
    output logic                 o_last_frame
);

    logic       r_valid;
    logic [7:0] r_sel;
    logic [6:0] r_seg;
    logic       r_last;

    // Refill the output register from a nonempty queue whenever it is empty or being drained.
    assign o_pop = i_q_status.nonempty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (o_pop) begin
            r_sel  <= dssf_pkg::select_for(i_frame.pos);
            r_seg  <= i_frame.last ? 7'h00 : dssf_pkg::seg_for(i_frame.digit);
            r_last <= i_frame.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_select_byte  = r_sel;
    assign o_segment_byte = r_seg;
    assign o_last_frame   = r_last;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the decimal seven-segment frame generator.
`timescale 1ns / 1ps

module testbench;

    // One display frame as it leaves the block.
    typedef struct packed {
        logic [7:0] select_byte;
        logic [6:0] segment_byte;
        logic       last_frame;
    } t_frame_word;

    // Segments a..g for the decimal digits, kept here independently of the package.
    localparam logic [6:0] DIGIT_SEGMENTS [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
        7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    localparam int SETTLE_CYCLES = 10;   // idle margin after the last owed frame
    localparam int HOLD_CYCLES   = 300;  // long receiver hold-off

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [15:0] i_value = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_select_byte;
    logic [6:0]  o_segment_byte;
    logic        o_last_frame;

    t_frame_word pending_frames [$];   // frames owed by the block, oldest first
    int          error_count    = 0;
    int          values_sent    = 0;
    int          frames_checked = 0;
    int          stall_cycles   = 0;   // cycles the input was offered but refused
    int          tx_idle_pct    = 0;
    int          rx_stall_pct   = 0;
    int          rx_hold_cycles = 0;

    decimal_seven_segment_frames uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_select_byte  (o_select_byte),
        .o_segment_byte (o_segment_byte),
        .o_last_frame   (o_last_frame)
    );

    always #1 i_clk = ~i_clk;

    // Work out the frames one value produces: a frame per position from the
    // highest down to 0, units digit first, then the blanking frame on position 0.
    function automatic void predict_frames(input logic [15:0] value);
        logic [15:0]  rest;
        int unsigned  digit;
        t_frame_word  frame;
        rest = value;
        for (int pos = dssf_pkg::DIGIT_COUNT - 1; pos >= 0; pos--) begin
            digit              = rest % 10;
            rest               = rest / 10;
            frame.select_byte  = 8'hFF & ~(8'h10 << pos);
            frame.segment_byte = DIGIT_SEGMENTS[digit];
            frame.last_frame   = 1'b0;
            pending_frames.push_back(frame);
        end
        frame.select_byte  = 8'hFF & ~8'h10;
        frame.segment_byte = 7'h00;
        frame.last_frame   = 1'b1;
        pending_frames.push_back(frame);
    endfunction

    // Receiver: drive i_ready at the falling edge. A requested hold-off wins over
    // the random stall; count it down here, cycle by cycle.
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            i_ready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Checker: compare every accepted frame with the oldest one owed.
    always @(posedge i_clk) begin
        t_frame_word want;
        if (i_rst_n && i_valid && !o_ready)
            stall_cycles++;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_frames.size() == 0) begin
                $error("unexpected frame: select %h segment %h last %b",
                       o_select_byte, o_segment_byte, o_last_frame);
                error_count++;
            end else begin
                want = pending_frames.pop_front();
                frames_checked++;
                if (o_select_byte !== want.select_byte) begin
                    $error("select_byte mismatch: expected %h, actual %h",
                           want.select_byte, o_select_byte);
                    error_count++;
                end
                if (o_segment_byte !== want.segment_byte) begin
                    $error("segment_byte mismatch: expected %h, actual %h",
                           want.segment_byte, o_segment_byte);
                    error_count++;
                end
                if (o_last_frame !== want.last_frame) begin
                    $error("last_frame mismatch: expected %b, actual %b",
                           want.last_frame, o_last_frame);
                    error_count++;
                end
            end
        end
    end

    // Offer one word, after a random idle gap, and hold it until it is taken.
    // Keep i_valid high between back-to-back words so it never toggles in one step.
    task automatic send_value(input logic [15:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            i_value <= 16'($urandom);
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do
            @(posedge i_clk);
        while (!o_ready);
        predict_frames(value);
        values_sent++;
    endtask

    // Drop the input and hold off until every owed frame has arrived.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // An even mix of values up to 9999, small ones below 100, wrapping ones and the full range.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(9999));
            2:       return 16'($urandom_range(99));
            default: return 16'($urandom_range(65535, 10000));
        endcase
    endfunction

    // Extremes of the field, every decimal digit in some position, and wrapping values.
    task automatic test_directed();
        logic [15:0] corner_values [] = '{
            16'd0, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
            16'd1234, 16'd5678, 16'd9012, 16'd3456, 16'd7890, 16'd9999,
            16'd10000, 16'd12345, 16'd19999, 16'd65535, 16'h5555, 16'hAAAA,
            16'h8000, 16'd1, 16'd4444, 16'd8080
        };
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        foreach (corner_values[k])
            send_value(corner_values[k]);
        wait_drained();
    endtask

    // Random words under one idling mix.
    task automatic test_random(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count)
            send_value(pick_value());
        wait_drained();
    endtask

    // Hold the receiver off for a long stretch while words keep coming, so the
    // frame queue fills and the block has to refuse input.
    task automatic test_input_stall();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        @(posedge i_clk);
        rx_hold_cycles = HOLD_CYCLES;
        repeat (12)
            send_value(pick_value());
        wait_drained();
    endtask

    // Send short bursts, pausing the sender until the block has emptied each time.
    task automatic test_drain_pause();
        tx_idle_pct  = 30;
        rx_stall_pct = 30;
        repeat (3) begin
            repeat (4)
                send_value(pick_value());
            wait_drained();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(125, 0, 0);
        test_random(125, 59, 0);
        test_random(125, 0, 59);
        test_random(125, 30, 30);
        test_input_stall();
        test_drain_pause();

        if (pending_frames.size() != 0) begin
            $error("%0d frames never arrived", pending_frames.size());
            error_count++;
        end
        $display("Sent %0d values and checked %0d frames: corner values, random values",
                 values_sent, frames_checked);
        $display("under four idling mixes, a long receiver hold-off (%0d refused cycles)",
                 stall_cycles);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== decimal_seven_segment_frames.f =====
sv/dssf_pkg.sv
sv/dssf_front.sv
sv/dssf_queue.sv
sv/dssf_back.sv
sv/decimal_seven_segment_frames.sv
sim/testbench.sv
